>>> src/erl_pkg.sv
// ----------------------------------------------------------------------------
// erl_pkg: shared types and codes for the entry ring
// Holds the stored entry layout, the result beat layout and request codes.
// ----------------------------------------------------------------------------
package erl_pkg;

    localparam int HANDLE_W = 32;
    localparam int LENGTH_W = 16;
    localparam int POS_W    = 20;

    // Request codes carried on req_type.
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_FIND = 1'b1;

    // One stored ring entry.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [LENGTH_W-1:0] length;
    } entry_t;

    // One result beat.
    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] hit_handle;
        logic [LENGTH_W-1:0] hit_length;
        logic [LENGTH_W-1:0] byte_within_entry;
        logic                evicted;
        logic [HANDLE_W-1:0] evicted_handle;
    } result_t;

    localparam result_t RESULT_ZERO = '0;

endpackage

>>> src/entry_ring_with_offset_lookup.sv
// ----------------------------------------------------------------------------
// entry_ring_with_offset_lookup: overwriting entry ring with offset search
// Add: writes the slot and reads its old contents, passes S_ADD, then done; the
// next start is accepted on the done cycle. Find: one RAM read per cycle; a hit
// ends the walk, a miss checks all valid entries, an empty ring skips the walk.
// Busy stays high until done; the receiver takes each result beat as shown.
// Reset clears the ring indices and full flag; entry RAM contents are not reset.
// ----------------------------------------------------------------------------
module entry_ring_with_offset_lookup #(
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         req_type,
    input  logic [erl_pkg::HANDLE_W-1:0] new_handle,
    input  logic [erl_pkg::LENGTH_W-1:0] new_length,
    input  logic [erl_pkg::POS_W-1:0]    char_position,
    output logic                         done,
    output logic                         hit,
    output logic [erl_pkg::HANDLE_W-1:0] hit_handle,
    output logic [erl_pkg::LENGTH_W-1:0] hit_length,
    output logic [erl_pkg::LENGTH_W-1:0] byte_within_entry,
    output logic                         evicted,
    output logic [erl_pkg::HANDLE_W-1:0] evicted_handle
);
    import erl_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    entry_t        mem_rdata;
    result_t       result;

    // Sequencer.
    erl_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .new_handle    (new_handle),
        .new_length    (new_length),
        .char_position (char_position),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .done          (done),
        .result        (result)
    );

    // Entry storage.
    erl_ram #(.DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Result beat fields.
    assign hit               = result.hit;
    assign hit_handle        = result.hit_handle;
    assign hit_length        = result.hit_length;
    assign byte_within_entry = result.byte_within_entry;
    assign evicted           = result.evicted;
    assign evicted_handle    = result.evicted_handle;

endmodule

>>> src/erl_ram.sv
// ----------------------------------------------------------------------------
// erl_ram: entry storage
// Simple dual-port synchronous RAM, one write and one registered read port.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module erl_ram #(
    parameter int DEPTH = 16,
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            clk,
    input  logic            we,
    input  logic [IW-1:0]   waddr,
    input  erl_pkg::entry_t wdata,
    input  logic            re,
    input  logic [IW-1:0]   raddr,
    output erl_pkg::entry_t rdata
);
    import erl_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Registered read, read-before-write on an address collision.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/erl_ctrl.sv
// ----------------------------------------------------------------------------
// erl_ctrl: ring sequencer
// Keeps the ring indices, performs adds with eviction and walks the stored
// entries for a find, one RAM read issued per cycle.
// ----------------------------------------------------------------------------
module erl_ctrl #(
    parameter int DEPTH = 16,
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           req_type,
    input  logic [erl_pkg::HANDLE_W-1:0]   new_handle,
    input  logic [erl_pkg::LENGTH_W-1:0]   new_length,
    input  logic [erl_pkg::POS_W-1:0]      char_position,
    output logic                           mem_we,
    output logic [IW-1:0]                  mem_waddr,
    output erl_pkg::entry_t                mem_wdata,
    output logic                           mem_re,
    output logic [IW-1:0]                  mem_raddr,
    input  erl_pkg::entry_t                mem_rdata,
    output logic                           done,
    output erl_pkg::result_t               result
);
    import erl_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int TW   = LENGTH_W + CW;
    localparam int CMPW = (TW > POS_W) ? TW : POS_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADD  = 2'd1;
    localparam logic [1:0] S_FIND = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IW-1:0]    widx_reg, widx_next;
    logic [IW-1:0]    ridx_reg, ridx_next;
    logic             full_reg, full_next;
    logic             evict_reg, evict_next;
    logic [IW-1:0]    iss_idx_reg, iss_idx_next;
    logic [CW-1:0]    n_iss_reg, n_iss_next;
    logic [CW-1:0]    n_chk_reg, n_chk_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [TW-1:0]    total_reg, total_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             dv_reg, dv_next;
    logic             done_reg, done_next;
    result_t          result_reg, result_next;

    logic             accept;
    logic             issue;
    logic [IW-1:0]    widx_inc;
    logic [CW-1:0]    valid_cnt;
    logic [TW-1:0]    sum;
    logic [CMPW-1:0]  pos_x;
    logic [CMPW-1:0]  offset_x;

    function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] i);
        ring_inc = (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign issue  = (state_reg == S_FIND) && (n_iss_reg != count_reg);

    // Number of valid entries at the time a find is accepted.
    assign widx_inc  = ring_inc(widx_reg);
    assign valid_cnt = full_reg ? CW'(DEPTH)
                     : (widx_reg >= ridx_reg) ? CW'(widx_reg) - CW'(ridx_reg)
                     : CW'(widx_reg) + CW'(DEPTH) - CW'(ridx_reg);

    // Running sum including the entry now returned by the RAM.
    assign sum      = total_reg + TW'(mem_rdata.length);
    assign pos_x    = CMPW'(pos_reg);
    assign offset_x = pos_x - CMPW'(total_reg);

    // RAM ports: adds write and read the slot at once, finds stream reads.
    assign mem_we    = accept && (req_type == REQ_ADD);
    assign mem_waddr = widx_reg;
    assign mem_wdata = '{handle: new_handle, length: new_length};
    assign mem_re    = (state_reg == S_IDLE) ? mem_we : issue;
    assign mem_raddr = (state_reg == S_IDLE) ? widx_reg : iss_idx_reg;

    // Sequencer next-state logic.
    always_comb
    begin
        state_next   = state_reg;
        widx_next    = widx_reg;
        ridx_next    = ridx_reg;
        full_next    = full_reg;
        evict_next   = evict_reg;
        iss_idx_next = iss_idx_reg;
        n_iss_next   = n_iss_reg;
        n_chk_next   = n_chk_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        pos_next     = pos_reg;
        dv_next      = 1'b0;
        done_next    = 1'b0;
        result_next  = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_ADD))
                begin
                    widx_next  = widx_inc;
                    ridx_next  = full_reg ? ring_inc(ridx_reg) : ridx_reg;
                    full_next  = full_reg || (widx_inc == ridx_next);
                    evict_next = full_reg;
                    state_next = S_ADD;
                end
                else if (accept)
                begin
                    pos_next     = char_position;
                    count_next   = valid_cnt;
                    iss_idx_next = ridx_reg;
                    n_iss_next   = '0;
                    n_chk_next   = '0;
                    total_next   = '0;
                    if (valid_cnt == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = RESULT_ZERO;
                    end
                    else
                    begin
                        state_next = S_FIND;
                    end
                end
            end
            S_ADD:
            begin
                // Old slot contents arrive now; report them when evicting.
                done_next                  = 1'b1;
                result_next                = RESULT_ZERO;
                result_next.evicted        = evict_reg;
                result_next.evicted_handle = evict_reg ? mem_rdata.handle : '0;
                state_next                 = S_IDLE;
            end
            S_FIND:
            begin
                if (issue)
                begin
                    iss_idx_next = ring_inc(iss_idx_reg);
                    n_iss_next   = n_iss_reg + 1'b1;
                end
                dv_next = issue;
                if (dv_reg)
                begin
                    if (pos_x < CMPW'(sum))
                    begin
                        done_next                     = 1'b1;
                        result_next                   = RESULT_ZERO;
                        result_next.hit               = 1'b1;
                        result_next.hit_handle        = mem_rdata.handle;
                        result_next.hit_length        = mem_rdata.length;
                        result_next.byte_within_entry = offset_x[LENGTH_W-1:0];
                        dv_next                       = 1'b0;
                        state_next                    = S_IDLE;
                    end
                    else
                    begin
                        total_next = sum;
                        n_chk_next = n_chk_reg + 1'b1;
                        if (CW'(n_chk_reg + 1'b1) == count_reg)
                        begin
                            done_next   = 1'b1;
                            result_next = RESULT_ZERO;
                            dv_next     = 1'b0;
                            state_next  = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            widx_reg  <= '0;
            ridx_reg  <= '0;
            full_reg  <= 1'b0;
            dv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            widx_reg  <= widx_next;
            ridx_reg  <= ridx_next;
            full_reg  <= full_next;
            dv_reg    <= dv_next;
            done_reg  <= done_next;
        end
    end

    // Walk bookkeeping and result payload.
    always_ff @(posedge clk)
    begin
        evict_reg   <= evict_next;
        iss_idx_reg <= iss_idx_next;
        n_iss_reg   <= n_iss_next;
        n_chk_reg   <= n_chk_next;
        count_reg   <= count_next;
        total_reg   <= total_next;
        pos_reg     <= pos_next;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    // A result beat is only presented once the sequencer is back to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result beat while sequencer busy");

    // A beat never reports both a find hit and an eviction.
    a_hit_xor_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(result_reg.hit && result_reg.evicted))
        else $error("hit and evicted both set");

    // Once full the ring stays full and both indices move together.
    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |=> full_reg)
        else $error("ring full flag cleared");

    a_full_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (widx_reg == ridx_reg))
        else $error("full ring with misaligned indices");

    // The walk never checks more entries than it has read, nor reads more than the valid count.
    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND) |-> (n_chk_reg <= n_iss_reg) && (n_iss_reg <= count_reg))
        else $error("find walk counters out of order");
`endif

endmodule
